// ===== rtl/core/tklt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tklt_pkg;

   // Built number of stored entries unless the top level is told otherwise.
   localparam int unsigned DEPTH_DEFAULT = 16;

   // Field widths of the ports.
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned RANK_W  = 4;
   localparam int unsigned FILL_W  = 5;
   localparam int unsigned CAP_W   = 5;
   localparam int unsigned REQ_W   = 2;

   // A readout shows at most this many entries, smallest first.
   localparam int unsigned MAX_RESULTS = 16;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READOUT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_READ
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear;
      logic trim;
      logic insert;
      logic read_step;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic over_cap;
      logic read_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/top_k_largest_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keeps the largest capacity values seen, smallest first, in a row of DEPTH
// compare-and-shift cells. An item is taken when start is high and busy is
// low; busy stays high until the item's work is done. A clear empties the store
// without leaving idle. An insert first trims entries while the capacity is
// below the fill, then the cells compare and shift together. During a readout
// the cells rotate one place a cycle toward cell 0, so the store is back in
// order once every held entry has passed. Results come one a cycle on
// rsp_valid, each valid for one cycle only, and there is no way to hold them
// off: the receiver must take every one.
// The configuration port is always ready and is meant to be written while idle.
module top_k_largest_tracker #(
   parameter int unsigned DEPTH = tklt_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [tklt_pkg::REQ_W-1:0]    req_type,
   input  wire logic [tklt_pkg::VALUE_W-1:0]  req_sample,
   output logic                               rsp_valid,
   output logic [tklt_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic [tklt_pkg::RANK_W-1:0]        rsp_out_rank,
   output logic                               rsp_entry_valid,
   output logic                               rsp_last,
   output logic [tklt_pkg::FILL_W-1:0]        rsp_fill,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tklt_pkg::CAP_W-1:0]    csr_data
);
   import tklt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // Sequencer.
   tklt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Cells, counters and result registers.
   tklt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .sample          (req_sample),
      .cap_write       (csr_valid && csr_ready),
      .cap_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_rank    (rsp_out_rank),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_last        (rsp_last),
      .rsp_fill        (rsp_fill)
   );

endmodule

`default_nettype wire

// ===== rtl/core/tklt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tklt_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tklt_pkg::REQ_W-1:0]    req_type,
   input  wire tklt_pkg::dp_status_type       status,
   output tklt_pkg::dp_cmd_type               cmd,
   output logic                               busy
);
   import tklt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_INSERT:  state_in = ST_INSERT;
                  REQ_READOUT: state_in = ST_READ;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_INSERT: begin
            if (!status.over_cap) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (status.read_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: an insert first trims the store down to the capacity, one
   // entry a cycle, then places the value.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = accept;
            if (accept && (req_type == REQ_CLEAR)) begin
               cmd.clear = 1'b1;
            end
         end
         ST_INSERT: begin
            cmd.trim   = status.over_cap;
            cmd.insert = !status.over_cap;
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/tklt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tklt_datapath #(
   parameter int unsigned DEPTH = tklt_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tklt_pkg::dp_cmd_type          cmd,
   output tklt_pkg::dp_status_type            status,
   input  wire logic [tklt_pkg::VALUE_W-1:0]  sample,
   input  wire logic                          cap_write,
   input  wire logic [tklt_pkg::CAP_W-1:0]    cap_data,
   output logic                               rsp_valid,
   output logic [tklt_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic [tklt_pkg::RANK_W-1:0]        rsp_out_rank,
   output logic                               rsp_entry_valid,
   output logic                               rsp_last,
   output logic [tklt_pkg::FILL_W-1:0]        rsp_fill
);
   import tklt_pkg::*;

   // Count width, and a common width for comparisons with the capacity.
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned WW = (CW > CAP_W) ? CW : CAP_W;

   // Sorted cells, ascending from cell 0.
   logic [VALUE_W-1:0] cell_ff [DEPTH];
   logic [VALUE_W-1:0] cell_in [DEPTH];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      step_ff;
   logic [CW-1:0]      step_in;
   logic [VALUE_W-1:0] sample_ff;
   logic [CAP_W-1:0]   cap_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [VALUE_W-1:0] rsp_value_in;
   logic [RANK_W-1:0]  rsp_rank_ff;
   logic [RANK_W-1:0]  rsp_rank_in;
   logic               rsp_entry_ff;
   logic               rsp_entry_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic [FILL_W-1:0]  rsp_fill_ff;
   logic [FILL_W-1:0]  rsp_fill_in;

   logic [WW-1:0]      count_w;
   logic [WW-1:0]      step_w;
   logic [WW-1:0]      cap_w;
   logic [WW-1:0]      eff_k;
   logic [WW-1:0]      n_out;
   logic               empty;
   logic               at_cap;
   logic [DEPTH:0]     lt;

   assign count_w = WW'(count_ff);
   assign step_w  = WW'(step_ff);
   assign cap_w   = WW'(cap_ff);
   assign empty   = (count_ff == '0);

   // Effective capacity: zero counts as one, anything above the depth saturates.
   always_comb begin
      if (cap_w == '0) begin
         eff_k = WW'(1);
      end else if (cap_w > WW'(DEPTH)) begin
         eff_k = WW'(DEPTH);
      end else begin
         eff_k = cap_w;
      end
   end

   assign at_cap = (count_w == eff_k);

   // Number of entries a readout shows.
   assign n_out = (count_w > WW'(MAX_RESULTS)) ? WW'(MAX_RESULTS) : count_w;

   assign status.over_cap  = (count_w > eff_k);
   assign status.read_done = empty || (step_w == (count_w - WW'(1)));

   // Each held cell compares itself with the new value; the flags form a prefix.
   always_comb begin
      lt = '0;
      for (int j = 0; j < DEPTH; j++) begin
         lt[j] = (count_w > WW'(j)) && (cell_ff[j] < sample_ff);
      end
   end

   // Per-cell next value: shift down for a trim or a drop, shift up for an
   // insert, rotate toward cell 0 within the held entries for a readout.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [WW-1:0] NXT = WW'(i + 1);

      logic [VALUE_W-1:0] up_val;
      logic [VALUE_W-1:0] dn_val;
      logic               dn_lt;

      if (i < DEPTH - 1) begin : g_up
         assign up_val = cell_ff[i+1];
      end else begin : g_top
         assign up_val = cell_ff[i];
      end

      if (i > 0) begin : g_dn
         assign dn_val = cell_ff[i-1];
         assign dn_lt  = lt[i-1];
      end else begin : g_bottom
         assign dn_val = sample_ff;
         assign dn_lt  = 1'b1;
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.trim) begin
            cell_in[i] = up_val;
         end else if (cmd.insert) begin
            if (at_cap) begin
               if (lt[i+1]) begin
                  cell_in[i] = up_val;
               end else if (lt[i]) begin
                  cell_in[i] = sample_ff;
               end
            end else begin
               if (!lt[i]) begin
                  cell_in[i] = dn_lt ? sample_ff : dn_val;
               end
            end
         end else if (cmd.read_step && !empty) begin
            if (NXT == count_w) begin
               cell_in[i] = cell_ff[0];
            end else if (NXT < count_w) begin
               cell_in[i] = up_val;
            end
         end
      end

      // Cell storage carries no reset.
      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // Fill count and readout step.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.trim) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.insert && !at_cap) begin
         count_in = count_ff + CW'(1);
      end

      step_in = step_ff;
      if (cmd.load) begin
         step_in = '0;
      end else if (cmd.read_step) begin
         step_in = step_ff + CW'(1);
      end
   end

   // Result of one readout step.
   always_comb begin
      rsp_valid_in = cmd.read_step && (empty || (step_w < WW'(MAX_RESULTS)));
      rsp_value_in = empty ? '0 : cell_ff[0];
      rsp_rank_in  = empty ? '0 : step_w[RANK_W-1:0];
      rsp_entry_in = !empty;
      rsp_last_in  = empty || (step_w == (n_out - WW'(1)));
      rsp_fill_in  = count_w[FILL_W-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cap_write) begin
            cap_ff <= cap_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fill_ff  <= rsp_fill_in;
      if (cmd.load) begin
         sample_ff <= sample;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_rank    = rsp_rank_ff;
   assign rsp_entry_valid = rsp_entry_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_fill        = rsp_fill_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tklt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tklt_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [tklt_pkg::REQ_W-1:0]    req_type,
   input  wire logic                          rsp_valid,
   input  wire logic [tklt_pkg::VALUE_W-1:0]  rsp_out_value,
   input  wire logic [tklt_pkg::RANK_W-1:0]   rsp_out_rank,
   input  wire logic                          rsp_entry_valid,
   input  wire logic                          rsp_last,
   input  wire logic [tklt_pkg::FILL_W-1:0]   rsp_fill
);
   import tklt_pkg::*;

   // The empty-store item is the only item of its readout and carries zeros.
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |->
         rsp_last && (rsp_fill == '0) && (rsp_out_rank == '0) && (rsp_out_value == '0))
      else $error("empty-store item malformed");

   // A stored entry implies a nonzero fill.
   a_entry_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |-> (rsp_fill != '0))
      else $error("entry item with zero fill");

   // Readout items come back to back with rising rank until the last one.
   a_rank_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_valid && rsp_entry_valid && (rsp_out_rank == $past(rsp_out_rank) + 4'd1))
      else $error("readout run broken");

   // An accepted readout keeps the block busy in the next cycle.
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_READOUT) |=> busy)
      else $error("readout accepted but block not busy");

   // An insert never produces an item right after acceptance.
   a_insert_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_INSERT) |=> !rsp_valid)
      else $error("insert produced an item");

endmodule

bind top_k_largest_tracker tklt_checker u_tklt_checker (.*);

`default_nettype wire
